FILE: design/pcm_fade_out_gain_macros.svh
// ----------------------------------------------------------------------------
// pcm_fade_out_gain_macros.svh
// Assertion macros shared by the fade-out gain design.
// ----------------------------------------------------------------------------
`ifndef PCM_FADE_OUT_GAIN_MACROS_SVH
`define PCM_FADE_OUT_GAIN_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked assertion, quiet while reset is applied.
`define PFO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds across reset.
`define PFO_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFO_ASSERT(label, clk, rst_n, prop, msg)
`define PFO_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

FILE: design/pfo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfo_pkg
// Types, codes and the gain table of the fade-out gain pipeline.
// ----------------------------------------------------------------------------
package pfo_pkg;

    localparam int TABLE_BITS  = 6;
    localparam int GAIN_BITS   = 8;
    localparam int DIV_STEPS   = 3 + TABLE_BITS;   // quotient bits of the fade index
    localparam int POS_W       = 32;
    localparam int SAMPLE_W    = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SHAMT_W     = 4;

    // sample formats
    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S24 = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_START    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 2'd3;

    localparam logic [POS_W-1:0] FADE_LENGTH_RST   = 32'd220500;
    localparam logic [1:0]       SAMPLE_FORMAT_RST = FMT_S16;

    localparam logic [7:0] U8_MID = 8'h80;

    localparam logic [GAIN_BITS-1:0] GAIN_ROM [2**TABLE_BITS] = '{
        8'hfd, 8'hfa, 8'hf7, 8'hf5, 8'hf2, 8'hef, 8'hed, 8'hea,
        8'he8, 8'he5, 8'he3, 8'he0, 8'hde, 8'hdb, 8'hd9, 8'hd7,
        8'hd4, 8'hd2, 8'hd0, 8'hce, 8'hcb, 8'hc9, 8'hc7, 8'hc5,
        8'hc3, 8'hc1, 8'hbf, 8'hbd, 8'hba, 8'hb8, 8'hb6, 8'hb5,
        8'hb3, 8'hb1, 8'haf, 8'had, 8'hab, 8'ha9, 8'ha7, 8'ha5,
        8'ha4, 8'ha2, 8'ha0, 8'h9e, 8'h9d, 8'h9b, 8'h99, 8'h98,
        8'h96, 8'h94, 8'h93, 8'h91, 8'h90, 8'h8e, 8'h8d, 8'h8b,
        8'h8a, 8'h88, 8'h87, 8'h85, 8'h84, 8'h82, 8'h81, 8'h80
    };

    // one beat on its way through the divider
    typedef struct packed {
        logic [POS_W-1:0]     rem;          // partial remainder, below fade length for faded beats
        logic [DIV_STEPS-1:0] quot;         // fade index, built MSB first
        logic [SAMPLE_W-1:0]  raw;          // sample, already masked to format
        logic [1:0]           fmt;
        logic                 bypass;       // pass the sample unchanged
        logic                 final_frame;
    } t_div_beat;

endpackage

FILE: design/pfo_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfo_in_if
// Input channel: a frame position and its raw sample.
// ----------------------------------------------------------------------------
interface pfo_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] position;
    logic [23:0] sample_in;

    modport source (output valid, output position, output sample_in, input ready);
    modport sink   (input valid, input position, input sample_in, output ready);
endinterface

FILE: design/pfo_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfo_out_if
// Output channel: processed sample and last-frame flag.
// ----------------------------------------------------------------------------
interface pfo_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] sample_out;
    logic        final_frame;

    modport source (output valid, output sample_out, output final_frame, input ready);
    modport sink   (input valid, input sample_out, input final_frame, output ready);
endinterface

FILE: design/pfo_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfo_front
// Window decode: compares position with the fade window, drops beats at or
// past the end, forms the offset and masks the sample.
// ----------------------------------------------------------------------------
module pfo_front
    import pfo_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fade_enable,
    input  logic [POS_W-1:0]    i_fade_start,
    input  logic [POS_W-1:0]    i_fade_length,
    input  logic [1:0]          i_sample_format,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [POS_W-1:0]    i_position,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output t_div_beat           o_beat
);

    logic [POS_W:0]    fade_end;
    logic [POS_W:0]    pos_next;
    logic              before_start;
    logic              past_end;
    logic              bypass;
    logic              emit;
    logic [SAMPLE_W-1:0] masked;
    logic              r_valid;
    t_div_beat         r_beat;
    t_div_beat         n_beat;

    assign fade_end     = {1'b0, i_fade_start} + {1'b0, i_fade_length};
    assign pos_next     = {1'b0, i_position} + {{POS_W{1'b0}}, 1'b1};
    assign before_start = i_position < i_fade_start;
    assign past_end     = {1'b0, i_position} >= fade_end;
    assign bypass       = !i_fade_enable || before_start;
    assign emit         = bypass || !past_end;

    always_comb begin
        case (i_sample_format)
            FMT_U8:  masked = {16'd0, i_sample[7:0]};
            FMT_S16: masked = {8'd0, i_sample[15:0]};
            default: masked = i_sample;
        endcase
    end

    always_comb begin
        n_beat.rem         = i_position - i_fade_start;
        n_beat.quot        = '0;
        n_beat.raw         = masked;
        n_beat.fmt         = i_sample_format;
        n_beat.bypass      = bypass;
        n_beat.final_frame = i_fade_enable && (pos_next == fade_end);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: design/pfo_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfo_div_step
// One restoring division step: one quotient bit of offset * 512 / length.
// ----------------------------------------------------------------------------
module pfo_div_step
    import pfo_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [POS_W-1:0] i_fade_length,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_div_beat        i_beat,
    output logic             o_valid,
    input  logic             i_ready,
    output t_div_beat        o_beat
);

    logic [POS_W:0] rem2;
    logic [POS_W:0] diff;
    logic           take;
    logic           r_valid;
    t_div_beat      r_beat;
    t_div_beat      n_beat;

    assign rem2 = {i_beat.rem, 1'b0};
    assign diff = rem2 - {1'b0, i_fade_length};
    assign take = rem2 >= {1'b0, i_fade_length};

    always_comb begin
        n_beat      = i_beat;
        n_beat.rem  = take ? diff[POS_W-1:0] : rem2[POS_W-1:0];
        n_beat.quot = {i_beat.quot[DIV_STEPS-2:0], take};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: design/pfo_scale.sv
`timescale 1ns / 1ps
`include "pcm_fade_out_gain_macros.svh"
// ----------------------------------------------------------------------------
// pfo_scale
// Gain lookup and multiply, then arithmetic shift, re-encode and output
// register; bypass beats pass their raw sample unchanged.
// ----------------------------------------------------------------------------
module pfo_scale
    import pfo_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_div_beat           i_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic                o_final_frame
);

    localparam int SV_W   = SAMPLE_W + 1;
    localparam int PROD_W = SV_W + GAIN_BITS + 1;

    // multiply stage
    logic signed [SV_W-1:0]   sval;
    logic [GAIN_BITS-1:0]     gain;
    logic signed [PROD_W-1:0] n_prod;
    logic [SHAMT_W-1:0]       n_shamt;
    logic                     mul_ready;
    logic                     r_mul_valid;
    logic signed [PROD_W-1:0] r_prod;
    logic [SHAMT_W-1:0]       r_shamt;
    logic [SAMPLE_W-1:0]      r_mul_raw;
    logic [1:0]               r_mul_fmt;
    logic                     r_mul_bypass;
    logic                     r_mul_final;

    // output stage
    logic signed [PROD_W-1:0] shifted;
    logic [SAMPLE_W-1:0]      n_sample;
    logic                     out_ready;
    logic                     r_out_valid;
    logic [SAMPLE_W-1:0]      r_out_sample;
    logic [1:0]               r_out_fmt;
    logic                     r_out_final;

    always_comb begin
        case (i_beat.fmt)
            FMT_U8:  sval = $signed({17'd0, i_beat.raw[7:0]}) - $signed({17'd0, U8_MID});
            FMT_S16: sval = $signed({{9{i_beat.raw[15]}}, i_beat.raw[15:0]});
            default: sval = $signed({i_beat.raw[SAMPLE_W-1], i_beat.raw});
        endcase
    end

    // both operands sign-extended to the full product width
    assign gain    = GAIN_ROM[i_beat.quot[TABLE_BITS-1:0]];
    assign n_prod  = PROD_W'(sval) * PROD_W'($signed({1'b0, gain}));
    assign n_shamt = {1'b0, i_beat.quot[DIV_STEPS-1:TABLE_BITS]} + SHAMT_W'(GAIN_BITS);

    assign out_ready = !r_out_valid || i_ready;
    assign mul_ready = !r_mul_valid || out_ready;
    assign o_ready   = mul_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (mul_ready) begin
            r_mul_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_ready) begin
            r_prod       <= n_prod;
            r_shamt      <= n_shamt;
            r_mul_raw    <= i_beat.raw;
            r_mul_fmt    <= i_beat.fmt;
            r_mul_bypass <= i_beat.bypass;
            r_mul_final  <= i_beat.final_frame;
        end
    end

    assign shifted = r_prod >>> r_shamt;

    always_comb begin
        if (r_mul_bypass) begin
            n_sample = r_mul_raw;
        end else begin
            case (r_mul_fmt)
                FMT_U8:  n_sample = {16'd0, shifted[7:0] ^ U8_MID};
                FMT_S16: n_sample = {8'd0, shifted[15:0]};
                default: n_sample = shifted[SAMPLE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_mul_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_sample <= n_sample;
            r_out_fmt    <= r_mul_fmt;
            r_out_final  <= r_mul_final;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_sample      = r_out_sample;
    assign o_final_frame = r_out_final;

    // bits above the sample width stay clear
    `PFO_ASSERT(a_u8_upper_clear, i_clk, i_rst_n, r_out_valid && r_out_fmt == FMT_U8 |-> r_out_sample[SAMPLE_W-1:8] == '0, "8-bit result has upper bits set")
    `PFO_ASSERT(a_s16_upper_clear, i_clk, i_rst_n, r_out_valid && r_out_fmt == FMT_S16 |-> r_out_sample[SAMPLE_W-1:16] == '0, "16-bit result has upper bits set")
    // a new output beat comes only from a filled multiply stage
    `PFO_ASSERT(a_out_from_mul, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_mul_valid), "output beat without a multiply beat")

endmodule

FILE: design/pcm_fade_out_gain.sv
`timescale 1ns / 1ps
`include "pcm_fade_out_gain_macros.svh"
// ----------------------------------------------------------------------------
// pcm_fade_out_gain
// Fade-out gain stage for one PCM channel: window decode, pipelined
// divider for the fade index, gain multiply and arithmetic shift.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents                     handshake
//  i_in      in   position, sample_in               valid / ready
//  o_out     out  sample_out, final_frame           valid / ready
//  cfg       in   i_cfg_idx, i_cfg_wdata            i_cfg_we, no wait
//
//  One beat per cycle sustained while the output is not stalled. Stages in
//  order: window decode, nine restoring divide steps, one per register
//  stage, gain multiply, shift and output register.
//  Beats at or past the fade end are dropped at the window decode and
//  leave a bubble.
//  Each stage holds while the one after it is full and stalled, so ready
//  only drops when every stage holds a beat; no beat is lost or repeated.
//  Synchronous active-low reset clears the valid bits and loads the
//  register defaults; the data path carries no reset.
//  Registers are read live, so write them only while the pipe is empty.
//
module pcm_fade_out_gain
    import pfo_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pfo_in_if.sink                i_in,
    pfo_out_if.source             o_out
);

    // configuration registers
    logic             r_fade_enable;
    logic [POS_W-1:0] r_fade_start;
    logic [POS_W-1:0] r_fade_length;
    logic [1:0]       r_sample_format;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_enable   <= 1'b0;
            r_fade_start    <= '0;
            r_fade_length   <= FADE_LENGTH_RST;
            r_sample_format <= SAMPLE_FORMAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FADE_ENABLE:   r_fade_enable   <= i_cfg_wdata[0];
                REG_FADE_START:    r_fade_start    <= i_cfg_wdata;
                REG_FADE_LENGTH:   r_fade_length   <= i_cfg_wdata;
                REG_SAMPLE_FORMAT: r_sample_format <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // stage links: index 0 is the window decode, 1..DIV_STEPS the divider
    logic      link_valid [DIV_STEPS+1];
    logic      link_ready [DIV_STEPS+1];
    t_div_beat link_beat  [DIV_STEPS+1];
    logic      all_full;

    pfo_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fade_enable   (r_fade_enable),
        .i_fade_start    (r_fade_start),
        .i_fade_length   (r_fade_length),
        .i_sample_format (r_sample_format),
        .i_valid         (i_in.valid),
        .o_ready         (i_in.ready),
        .i_position      (i_in.position),
        .i_sample        (i_in.sample_in),
        .o_valid         (link_valid[0]),
        .i_ready         (link_ready[0]),
        .o_beat          (link_beat[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        pfo_div_step u_step (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_fade_length (r_fade_length),
            .i_valid       (link_valid[g]),
            .o_ready       (link_ready[g]),
            .i_beat        (link_beat[g]),
            .o_valid       (link_valid[g+1]),
            .i_ready       (link_ready[g+1]),
            .o_beat        (link_beat[g+1])
        );
    end

    pfo_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (link_valid[DIV_STEPS]),
        .o_ready       (link_ready[DIV_STEPS]),
        .i_beat        (link_beat[DIV_STEPS]),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_sample      (o_out.sample_out),
        .o_final_frame (o_out.final_frame)
    );

    always_comb begin
        all_full = o_out.valid;
        for (int k = 0; k <= DIV_STEPS; k++) begin
            all_full = all_full && link_valid[k];
        end
    end

    // back-pressure reaches the input only with every stage occupied
    `PFO_ASSERT(a_stall_only_full, i_clk, i_rst_n, !i_in.ready |-> all_full, "input stalled with a free stage")
    // nothing leaves straight after reset
    `PFO_ASSERT_NR(a_rst_no_out, i_clk, !$past(i_rst_n) |-> !o_out.valid, "output valid after reset")

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fade-out gain stage. A queue of pending beats
// feeds a clocked driver; a clocked monitor predicts each accepted beat
// against its own copy of the registers and gain table, and checks every
// output beat against the oldest prediction. Directed corner beats come
// first, then randomised fade windows with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import pfo_pkg::*;

    localparam int          RUN_LIMIT   = 400000;  // cycles, far above a clean run
    localparam int          DRAIN_WAIT  = 16;      // pipe is 12 deep
    localparam int          HOLD_CYCLES = 300;     // long receiver hold-off
    localparam logic [1:0]  FMT_RSVD    = 2'd3;    // unused code, behaves as 24-bit

    // own copy of the gain curve
    localparam logic [7:0] FADE_GAIN_LUT [64] = '{
        8'hfd, 8'hfa, 8'hf7, 8'hf5, 8'hf2, 8'hef, 8'hed, 8'hea,
        8'he8, 8'he5, 8'he3, 8'he0, 8'hde, 8'hdb, 8'hd9, 8'hd7,
        8'hd4, 8'hd2, 8'hd0, 8'hce, 8'hcb, 8'hc9, 8'hc7, 8'hc5,
        8'hc3, 8'hc1, 8'hbf, 8'hbd, 8'hba, 8'hb8, 8'hb6, 8'hb5,
        8'hb3, 8'hb1, 8'haf, 8'had, 8'hab, 8'ha9, 8'ha7, 8'ha5,
        8'ha4, 8'ha2, 8'ha0, 8'h9e, 8'h9d, 8'h9b, 8'h99, 8'h98,
        8'h96, 8'h94, 8'h93, 8'h91, 8'h90, 8'h8e, 8'h8d, 8'h8b,
        8'h8a, 8'h88, 8'h87, 8'h85, 8'h84, 8'h82, 8'h81, 8'h80
    };

    typedef struct packed {
        logic [31:0] position;
        logic [23:0] sample;
    } t_pcm_beat;

    typedef struct packed {
        logic [23:0] sample_out;
        logic        final_frame;
    } t_faded_beat;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pfo_in_if  in_ch ();
    pfo_out_if out_ch ();

    pcm_fade_out_gain i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // register shadow, updated with every write
    logic        cfg_enable;
    logic [31:0] cfg_start;
    logic [31:0] cfg_length;
    logic [1:0]  cfg_format;

    t_pcm_beat   pending_q [$];     // beats still to be offered
    t_faded_beat faded_q   [$];     // predicted output beats, oldest first

    int  n_queued;
    int  n_taken;
    int  n_errors;
    int  cycle_cnt;
    int  gap_pct;                   // sender idle chance, percent
    int  stall_pct;                 // receiver stall chance, percent
    int  hold_req;                  // bumped to ask for one long hold-off
    int  hold_seen;
    int  hold_cnt;
    bit  in_taken;                  // beat accepted at the last rising edge

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > RUN_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Expected result of one beat. Returns 0 where the beat yields nothing,
    // i.e. at or past the fade end (end formed at 33 bits, no wrap).
    // ------------------------------------------------------------------------
    function automatic bit fade_predict(input logic [31:0] pos, input logic [23:0] raw_in,
                                        output t_faded_beat res);
        logic [32:0] fade_end;
        logic [23:0] mask;
        logic [23:0] raw;
        logic [31:0] offset;
        logic [40:0] idx;
        logic [7:0]  gain;
        int          shift;
        longint      v;
        longint      scaled;
        logic [63:0] bits;

        fade_end = {1'b0, cfg_start} + {1'b0, cfg_length};
        case (cfg_format)
            FMT_U8:  mask = 24'h0000ff;
            FMT_S16: mask = 24'h00ffff;
            default: mask = 24'hffffff;
        endcase
        raw = raw_in & mask;
        res = '0;

        // fade off, or ahead of the window: straight through
        if (!cfg_enable || pos < cfg_start) begin
            res.sample_out  = raw;
            res.final_frame = cfg_enable && (({1'b0, pos} + 33'd1) == fade_end);
            return 1'b1;
        end

        // also covers a zero-length window, so no divide by zero below
        if ({1'b0, pos} >= fade_end)
            return 1'b0;

        offset = pos - cfg_start;
        idx    = {offset, 9'd0} / {9'd0, cfg_length};
        gain   = FADE_GAIN_LUT[idx[5:0]];
        shift  = int'(idx[8:6]) + 8;

        case (cfg_format)
            FMT_U8:  v = longint'(raw[7:0]) - 128;
            FMT_S16: v = longint'($signed(raw[15:0]));
            default: v = longint'($signed(raw[23:0]));
        endcase
        scaled = (v * longint'(gain)) >>> shift;   // floor towards minus infinity
        bits   = 64'(scaled);
        if (cfg_format == FMT_U8)
            bits = bits ^ 64'h80;
        res.sample_out  = bits[23:0] & mask;
        res.final_frame = ({1'b0, pos} + 33'd1) == fade_end;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers queued beats, idles at random, holds while stalled
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_pcm_beat b;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // beat still waiting, keep it steady
        end else if (pending_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
            b = pending_q.pop_front();
            in_ch.valid     <= 1'b1;
            in_ch.position  <= b.position;
            in_ch.sample_in <= b.sample;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt     = hold_cnt - 1;
            out_ch.ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen    = hold_req;
            hold_cnt     = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check output beats, predict accepted input beats
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_faded_beat want;
        t_faded_beat pred;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (faded_q.size() == 0) begin
                    $error("output beat with nothing expected: sample_out %06h final_frame %0b",
                           out_ch.sample_out, out_ch.final_frame);
                    n_errors++;
                end else begin
                    want = faded_q.pop_front();
                    if (out_ch.sample_out !== want.sample_out) begin
                        $error("sample_out mismatch: expected %06h, actual %06h",
                               want.sample_out, out_ch.sample_out);
                        n_errors++;
                    end
                    if (out_ch.final_frame !== want.final_frame) begin
                        $error("final_frame mismatch: expected %0b, actual %0b",
                               want.final_frame, out_ch.final_frame);
                        n_errors++;
                    end
                end
            end
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                n_taken++;
                if (fade_predict(in_ch.position, in_ch.sample_in, pred))
                    faded_q.push_back(pred);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            REG_FADE_ENABLE:   cfg_enable = data[0];
            REG_FADE_START:    cfg_start  = data;
            REG_FADE_LENGTH:   cfg_length = data;
            REG_SAMPLE_FORMAT: cfg_format = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(input logic [31:0] pos, input logic [23:0] smp);
        t_pcm_beat b;
        b.position = pos;
        b.sample   = smp;
        pending_q.push_back(b);
        n_queued++;
    endtask

    // all beats in, all results out, then a DRAIN_WAIT pause for dropped beats
    task automatic wait_idle();
        while (n_taken != n_queued || faded_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [32:0] fade_end;
        logic [31:0] seq_pos;
        logic [31:0] stride;
        logic [31:0] pos;
        logic [23:0] smp;
        int          pick;

        // known values on every input from time zero
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_FADE_ENABLE;
        i_cfg_wdata     = '0;
        in_ch.valid     = 1'b0;
        in_ch.position  = '0;
        in_ch.sample_in = '0;
        out_ch.ready    = 1'b0;
        cfg_enable      = 1'b0;
        cfg_start       = '0;
        cfg_length      = FADE_LENGTH_RST;
        cfg_format      = SAMPLE_FORMAT_RST;
        n_queued  = 0;
        n_taken   = 0;
        n_errors  = 0;
        cycle_cnt = 0;
        gap_pct   = 18;
        stall_pct = 18;
        hold_req  = 0;
        hold_seen = 0;
        hold_cnt  = 0;
        in_taken  = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed: reset defaults, fade off, flag must stay low
        queue_beat(32'h0000_0000, 24'h000000);
        queue_beat(32'hffff_ffff, 24'hffffff);
        queue_beat(32'd220499,    24'h123456);
        wait_idle();

        // --- directed: short window [100, 164), 16-bit extremes and edges
        cfg_write(REG_FADE_ENABLE,   32'hffff_fffe | 32'd1);
        cfg_write(REG_FADE_START,    32'd100);
        cfg_write(REG_FADE_LENGTH,   32'd64);
        cfg_write(REG_SAMPLE_FORMAT, {30'h3fff_ffff, FMT_S16});
        queue_beat(32'd99,        24'h008000);   // just ahead of the window
        queue_beat(32'd100,       24'h008000);   // most negative
        queue_beat(32'd100,       24'h007fff);   // most positive
        queue_beat(32'd101,       24'hffffff);   // -1 with excess bits set
        queue_beat(32'd163,       24'h000001);   // last frame
        queue_beat(32'd164,       24'h001234);   // fade end, dropped
        queue_beat(32'hffff_ffff, 24'h005555);   // far past the end
        wait_idle();

        cfg_write(REG_SAMPLE_FORMAT, {30'd0, FMT_U8});
        queue_beat(32'd100, 24'h000000);
        queue_beat(32'd130, 24'h0000ff);
        queue_beat(32'd163, 24'h0abc80);         // mid-scale, upper bits ignored
        wait_idle();

        cfg_write(REG_SAMPLE_FORMAT, {30'd0, FMT_S24});
        queue_beat(32'd100, 24'h800000);
        queue_beat(32'd150, 24'h7fffff);
        wait_idle();

        cfg_write(REG_SAMPLE_FORMAT, {30'd0, FMT_RSVD});
        queue_beat(32'd120, 24'hff8000);
        wait_idle();

        // --- directed: empty window, no divide may happen
        cfg_write(REG_SAMPLE_FORMAT, {30'd0, FMT_S16});
        cfg_write(REG_FADE_START,    32'd50);
        cfg_write(REG_FADE_LENGTH,   32'd0);
        queue_beat(32'd49, 24'h004321);          // flagged as last frame
        queue_beat(32'd50, 24'h004321);          // dropped
        wait_idle();

        // --- directed: fade end beyond 32 bits
        cfg_write(REG_FADE_START,  32'hffff_ffff);
        cfg_write(REG_FADE_LENGTH, 32'd1);
        queue_beat(32'hffff_ffff, 24'h008001);
        queue_beat(32'hffff_fffe, 24'h00abcd);
        wait_idle();

        cfg_write(REG_FADE_START,  32'd0);
        cfg_write(REG_FADE_LENGTH, 32'hffff_ffff);
        queue_beat(32'h8000_0000, 24'h008000);
        queue_beat(32'hffff_fffe, 24'h007fff);   // last frame
        queue_beat(32'hffff_ffff, 24'h001111);   // at the end, dropped
        wait_idle();

        // --- random windows
        for (int ph = 0; ph < 18; ph++) begin
            gap_pct   = (ph == 3) ? 0 : 18;      // one long stretch with no idling
            stall_pct = (ph == 3) ? 0 : 18;

            cfg_write(REG_FADE_ENABLE, {31'($urandom_range(32'h7fff_ffff)), 1'b0}
                                       | 32'($urandom_range(9) != 0));
            case ($urandom_range(3))
                0:       cfg_write(REG_FADE_START, 32'd0);
                1:       cfg_write(REG_FADE_START, $urandom_range(1000));
                2:       cfg_write(REG_FADE_START, $urandom);
                default: cfg_write(REG_FADE_START, 32'hffff_ffff - $urandom_range(300));
            endcase
            case ($urandom_range(7))
                0:       cfg_write(REG_FADE_LENGTH, 32'd0);
                1:       cfg_write(REG_FADE_LENGTH, $urandom_range(4, 1));
                2, 3:    cfg_write(REG_FADE_LENGTH, $urandom_range(200, 8));
                4:       cfg_write(REG_FADE_LENGTH, $urandom_range(5000, 201));
                5:       cfg_write(REG_FADE_LENGTH, $urandom);
                6:       cfg_write(REG_FADE_LENGTH, 32'hffff_ffff);
                default: cfg_write(REG_FADE_LENGTH, $urandom_range(70000, 500));
            endcase
            cfg_write(REG_SAMPLE_FORMAT, $urandom);

            if (ph == 6)
                hold_req++;                      // block fills and backs up

            fade_end = {1'b0, cfg_start} + {1'b0, cfg_length};
            seq_pos  = cfg_start;
            stride   = 32'd1;
            for (int k = 0; k < 100; k++) begin
                // restart the ascending run now and then
                if (k % 40 == 0) begin
                    stride = (cfg_length > 2048 && $urandom_range(1)) ? (cfg_length >> 9)
                                                                       : 32'd1;
                    case ($urandom_range(2))
                        0:       seq_pos = cfg_start - $urandom_range(6);
                        1:       seq_pos = fade_end[31:0] - stride * $urandom_range(30, 1);
                        default: seq_pos = cfg_start
                                           + ($urandom % ((cfg_length == 0) ? 32'd1
                                                                            : cfg_length));
                    endcase
                end
                pick = $urandom_range(99);
                if (pick < 70) begin
                    pos     = seq_pos;
                    seq_pos = seq_pos + stride;
                end else if (pick < 90) begin
                    pos = ($urandom_range(1) ? cfg_start : fade_end[31:0])
                          + $urandom_range(16) - 32'd8;
                end else begin
                    pos = $urandom;
                end
                case ($urandom_range(15))
                    0:       smp = 24'h000000;
                    1:       smp = 24'hffffff;
                    2:       smp = 24'h800000;
                    3:       smp = 24'h7fffff;
                    4:       smp = {8'($urandom), 16'h8000};
                    5:       smp = {8'($urandom), 16'h7fff};
                    6:       smp = {16'($urandom), 8'h80};
                    default: smp = 24'($urandom);
                endcase
                queue_beat(pos, smp);
            end
            wait_idle();
        end

        // --- wind down, bounded
        while (n_taken != n_queued)
            @(posedge i_clk);
        for (int w = 0; w < 2000 && faded_q.size() != 0; w++)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (faded_q.size() != 0) begin
            $error("%0d expected output beats never arrived", faded_q.size());
            n_errors++;
        end

        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/pfo_pkg.sv
design/pfo_in_if.sv
design/pfo_out_if.sv
design/pfo_front.sv
design/pfo_div_step.sv
design/pfo_scale.sv
design/pcm_fade_out_gain.sv
dv/tb.sv
